@@ src/zrle_pkg.sv @@
// Shared types and constants for the zero run-length encoder.
`default_nettype none
package zrle_pkg;

  localparam int COEFF_W = 32;
  localparam int RUN_W   = 16;

  // Longest run that one marker can carry.
  localparam logic [RUN_W-1:0] MAX_RUN = 16'd65535;

  // Command queue between front and back.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic {
    TOK_VALUE  = 1'b0,
    TOK_MARKER = 1'b1
  } tok_kind_t;

  // One command per accepted item that yields tokens. Token A (a marker of
  // a_len) goes out first when two is set; token B always goes out and
  // closes the item.
  typedef struct packed {
    logic               two;
    logic [RUN_W-1:0]   a_len;
    tok_kind_t          b_kind;
    logic [RUN_W-1:0]   b_len;
    logic [COEFF_W-1:0] b_val;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ src/zrle_front.sv @@
// Front end: accepts coefficients, tracks the zero run and issues token commands.
`default_nettype none
module zrle_front
  import zrle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [COEFF_W-1:0] in_tdata,
  input  wire logic               in_tlast,
  input  wire q_stat_t            q_stat,
  output logic                    push,
  output cmd_t                    push_cmd
);

  logic             run_mode_r, run_mode_nxt;
  logic [RUN_W-1:0] count_r, count_nxt;
  logic             accept, is_zero, at_max, emit;
  logic [RUN_W-1:0] count_inc;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign is_zero   = (in_tdata[COEFF_W-2:0] == '0);
  assign at_max    = (count_r >= MAX_RUN);
  assign count_inc = count_r + 1'b1;

  always_comb begin
    run_mode_nxt    = cfg_wr_en ? cfg_wr_data : run_mode_r;
    count_nxt       = count_r;
    emit            = 1'b1;
    push_cmd.two    = 1'b0;
    push_cmd.a_len  = count_r;
    push_cmd.b_kind = TOK_MARKER;
    push_cmd.b_len  = '0;
    push_cmd.b_val  = '0;
    push_cmd.last   = in_tlast;
    if (run_mode_r && is_zero) begin
      if (at_max) begin
        // full run closes; this zero starts a new one
        push_cmd.a_len = MAX_RUN;
        if (in_tlast) begin
          push_cmd.two   = 1'b1;
          push_cmd.b_len = {{(RUN_W-1){1'b0}}, 1'b1};
          count_nxt      = '0;
        end else begin
          push_cmd.b_len = MAX_RUN;
          count_nxt      = {{(RUN_W-1){1'b0}}, 1'b1};
        end
      end else if (in_tlast) begin
        push_cmd.b_len = count_inc;
        count_nxt      = '0;
      end else begin
        emit      = 1'b0;
        count_nxt = count_inc;
      end
    end else begin
      // flush pending run, then the value itself
      push_cmd.two    = (count_r != '0);
      push_cmd.b_kind = TOK_VALUE;
      push_cmd.b_val  = in_tdata;
      count_nxt       = '0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r <= 1'b1;
      count_r    <= '0;
    end else begin
      run_mode_r <= run_mode_nxt;
      if (accept) count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_RUN)
    else $error("zero run count above limit");

endmodule
`default_nettype wire

@@ src/zrle_cmd_fifo.sv @@
// Small command queue between the front end and the token emitter.
`default_nettype none
module zrle_cmd_fifo
  import zrle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_stat_t   q_stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("command queue underflow");

endmodule
`default_nettype wire

@@ src/zrle_back.sv @@
// Back end: expands queued commands into tokens in the output register.
`default_nettype none
module zrle_back
  import zrle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        head,
  input  wire q_stat_t     q_stat,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tlast,
  output logic [1:0]       out_tuser
);

  logic               phase_r, phase_nxt;
  logic               valid_r, valid_nxt;
  logic               load, take_a;
  logic [RUN_W-1:0]   len_r, len_nxt;
  logic [COEFF_W-1:0] val_r, val_nxt;
  tok_kind_t          kind_r, kind_nxt;
  logic               idone_r, idone_nxt;
  logic               sdone_r, sdone_nxt;

  assign load   = !valid_r || out_tready;
  assign take_a = head.two && !phase_r;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = load ? 1'b0 : valid_r;
    pop       = 1'b0;
    len_nxt   = len_r;
    val_nxt   = val_r;
    kind_nxt  = kind_r;
    idone_nxt = idone_r;
    sdone_nxt = sdone_r;
    if (load && !q_stat.empty) begin
      valid_nxt = 1'b1;
      if (take_a) begin
        kind_nxt  = TOK_MARKER;
        len_nxt   = head.a_len;
        val_nxt   = '0;
        idone_nxt = 1'b0;
        sdone_nxt = 1'b0;
        phase_nxt = 1'b1;
      end else begin
        kind_nxt  = head.b_kind;
        len_nxt   = head.b_len;
        val_nxt   = head.b_val;
        idone_nxt = 1'b1;
        sdone_nxt = head.last;
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    val_r   <= val_nxt;
    kind_r  <= kind_nxt;
    idone_r <= idone_nxt;
    sdone_r <= sdone_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {val_r, len_r};
  assign out_tlast  = sdone_r;
  assign out_tuser  = {idone_r, kind_r};

  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_stat.empty && head.two))
    else $error("second token pending without a two-token command");

  a_marker_first: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !idone_r) |-> (kind_r == TOK_MARKER))
    else $error("leading token of an item is not a marker");

endmodule
`default_nettype wire

@@ src/zero_run_length_encoder.sv @@
// Top level of the zero run-length encoder: front end, command queue, emitter.
//
// Input stream (in_*): one coefficient bit pattern per request on in_tdata,
// in_tlast set on the final coefficient of the data set. A coefficient is
// zero when bits 30..0 are clear, so +0 and -0 both count.
// Output stream (out_*): tokens. A value token carries the coefficient, a
// marker token carries the length of a skipped zero run (at most 65535).
// cfg_wr_en/cfg_wr_data write run_mode_enable; write it only while idle.
//
// A token is registered in the command queue and then in the output register
// before it shows on out_tvalid.
// Throughput: one item per cycle while out_tready stays high and each item
// yields at most one token; an item that closes a run and carries a value
// yields two tokens. The single output register paces this, and the
// four-entry command queue soaks up the extra token so input keeps flowing.
// Zeros inside a run yield no token and only advance the run count.
// Reset: run mode on, no run pending, queue and output register empty.
// Receiver stall: the output register holds its token, the queue fills, and
// in_tready drops once all four entries are in use.
`default_nettype none
module zero_run_length_encoder
  import zrle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration: run_mode_enable
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  // input channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [COEFF_W-1:0] in_tdata,   // [31:0] coeff_bits
  input  wire logic               in_tlast,   // stream_end
  // result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [47:0]             out_tdata,  // [15:0] run_length, [47:16] value_bits
  output logic                    out_tlast,  // stream_done
  output logic [1:0]              out_tuser   // [0] token_kind, [1] item_done
);

  cmd_t    push_cmd, head;
  logic    push, pop;
  q_stat_t q_stat;

  // Classify each coefficient and track the pending run.
  zrle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Hold commands so front and back can stall independently.
  zrle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Expand each command into one or two tokens.
  zrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
